>>> rtl/matrix_orientation_undo_assert.svh
// Assertion macros shared by the matrix orientation undo checker.
// Needs clk and rst_n in the scope of use.
`ifndef MATRIX_ORIENTATION_UNDO_ASSERT_SVH
`define MATRIX_ORIENTATION_UNDO_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MOU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MOU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mou_pkg.sv
// Shared constants, codes and control structs for the matrix orientation undo block.
// No dependencies.
package mou_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int LOAD_W      = 7;
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_TOKEN  = 2'd1,
        MODE_FINISH = 2'd2
    } mode_t;

    localparam logic OP_TURN = 1'b0;
    localparam logic OP_FLIP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

    typedef struct packed {
        logic load_we;   // store the element of the accepted transaction
        logic token_en;  // apply the operation token
        logic start;     // latch orientation, clear job state, restart emit counters
        logic issue;     // read one element and load the output register
    } cmd_t;

    typedef struct packed {
        logic at_end;    // the emit counters point at the final element
    } status_t;

endpackage

>>> rtl/mou_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mou_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/mou_ctrl.sv
// Controller: decodes input transactions, sequences the emit pass, owns output valid.
// Depends on mou_pkg.
module mou_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic [mou_pkg::MODE_W-1:0]  s_tuser,
    output logic                        s_tready,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    input  mou_pkg::status_t            stat,
    output mou_pkg::cmd_t               cmd
);
    import mou_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;
    logic   accept;
    mode_t  mode;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (mode)
            MODE_LOAD:   cmd.load_we  = accept;
            MODE_TOKEN:  cmd.token_en = accept;
            MODE_FINISH: cmd.start    = accept;
            default:     ;
        endcase
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // output register doubles as the RAM read register
                cmd.issue = !valid_reg || m_tready;
                if (cmd.issue && stat.at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        valid_next = cmd.issue || (valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

>>> rtl/mou_dp.sv
// Datapath: config registers, job state, element store, emit counters and address mapping.
// Depends on mou_pkg and mou_ram.
module mou_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mou_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mou_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [mou_pkg::DATA_W-1:0]     element,
    input  logic                           operation,
    input  mou_pkg::cmd_t                  cmd,
    output mou_pkg::status_t               stat,
    output logic [mou_pkg::DATA_W-1:0]     value,
    output logic [mou_pkg::DIM_W-1:0]      out_rows,
    output logic [mou_pkg::DIM_W-1:0]      out_cols,
    output logic                           last
);
    import mou_pkg::*;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] res;
        res = d;
        if (d == '0)
        begin
            res = DIM_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

    logic [DIM_W-1:0]  rows_reg, rows_next;
    logic [DIM_W-1:0]  cols_reg, cols_next;
    logic [LOAD_W-1:0] load_reg, load_next;
    logic              flip_reg, flip_next;
    logic [1:0]        turn_reg, turn_next;

    // orientation latched at finish
    logic [DIM_W-1:0]  rows_s_reg, rows_s_next;
    logic [DIM_W-1:0]  cols_s_reg, cols_s_next;
    logic [DIM_W-1:0]  orow_reg, orow_next;
    logic [DIM_W-1:0]  ocol_reg, ocol_next;
    logic [1:0]        turn_s_reg, turn_s_next;
    logic              flip_s_reg, flip_s_next;

    logic [IDX_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  c_reg, c_next;

    logic [DIM_W-1:0]  orows_reg, orows_next;
    logic [DIM_W-1:0]  ocols_reg, ocols_next;
    logic              last_reg, last_next;

    logic [DIM_W-1:0]  rows_c, cols_c;
    logic              row_end, col_end;
    logic [DIM_W-1:0]  r_w, c_w, pr_w, pc_w, pr_f;
    logic [LOAD_W-1:0] src_idx;
    logic              store_we;

    assign rows_c = clamp_dim(rows_reg);
    assign cols_c = clamp_dim(cols_reg);

    assign row_end     = ({1'b0, r_reg} == orow_reg - DIM_W'(1));
    assign col_end     = ({1'b0, c_reg} == ocol_reg - DIM_W'(1));
    assign stat.at_end = row_end && col_end;

    // source position of output (r, c) after undoing the turns, then the flip
    always_comb
    begin
        r_w = {1'b0, r_reg};
        c_w = {1'b0, c_reg};
        case (turn_s_reg)
            2'd0:
            begin
                pr_w = r_w;
                pc_w = c_w;
            end
            2'd1:
            begin
                pr_w = c_w;
                pc_w = cols_s_reg - DIM_W'(1) - r_w;
            end
            2'd2:
            begin
                pr_w = rows_s_reg - DIM_W'(1) - r_w;
                pc_w = cols_s_reg - DIM_W'(1) - c_w;
            end
            default:
            begin
                pr_w = rows_s_reg - DIM_W'(1) - c_w;
                pc_w = r_w;
            end
        endcase
        pr_f    = flip_s_reg ? (rows_s_reg - DIM_W'(1) - pr_w) : pr_w;
        src_idx = LOAD_W'(pr_f[IDX_W-1:0]) * LOAD_W'(cols_s_reg)
                + LOAD_W'(pc_w[IDX_W-1:0]);
    end

    always_comb
    begin
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        load_next   = load_reg;
        flip_next   = flip_reg;
        turn_next   = turn_reg;
        rows_s_next = rows_s_reg;
        cols_s_next = cols_s_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        turn_s_next = turn_s_reg;
        flip_s_next = flip_s_reg;
        r_next      = r_reg;
        c_next      = c_reg;

        if (cfg_we && cfg_index == REG_ROWS)
        begin
            rows_next = cfg_data;
        end
        if (cfg_we && cfg_index == REG_COLS)
        begin
            cols_next = cfg_data;
        end

        // a full store ignores further loads
        if (store_we)
        begin
            load_next = load_reg + LOAD_W'(1);
        end

        if (cmd.token_en)
        begin
            if (operation == OP_FLIP)
            begin
                flip_next = !flip_reg;
            end
            else if (!flip_reg)
            begin
                turn_next = turn_reg + 2'd1;
            end
            else
            begin
                turn_next = turn_reg - 2'd1;
            end
        end

        if (cmd.start)
        begin
            rows_s_next = rows_c;
            cols_s_next = cols_c;
            orow_next   = turn_reg[0] ? cols_c : rows_c;
            ocol_next   = turn_reg[0] ? rows_c : cols_c;
            turn_s_next = turn_reg;
            flip_s_next = flip_reg;
            load_next   = '0;
            flip_next   = 1'b0;
            turn_next   = 2'd0;
            r_next      = '0;
            c_next      = '0;
        end
        else if (cmd.issue)
        begin
            if (col_end)
            begin
                c_next = '0;
                r_next = r_reg + IDX_W'(1);
            end
            else
            begin
                c_next = c_reg + IDX_W'(1);
            end
        end
    end

    assign store_we = cmd.load_we && !load_reg[LOAD_W-1];

    always_comb
    begin
        orows_next = cmd.issue ? orow_reg    : orows_reg;
        ocols_next = cmd.issue ? ocol_reg    : ocols_reg;
        last_next  = cmd.issue ? stat.at_end : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= DIM_W'(1);
            cols_reg <= DIM_W'(1);
            load_reg <= '0;
            flip_reg <= 1'b0;
            turn_reg <= 2'd0;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            load_reg <= load_next;
            flip_reg <= flip_next;
            turn_reg <= turn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_s_reg <= rows_s_next;
        cols_s_reg <= cols_s_next;
        orow_reg   <= orow_next;
        ocol_reg   <= ocol_next;
        turn_s_reg <= turn_s_next;
        flip_s_reg <= flip_s_next;
        r_reg      <= r_next;
        c_reg      <= c_next;
        orows_reg  <= orows_next;
        ocols_reg  <= ocols_next;
        last_reg   <= last_next;
    end

    mou_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (load_reg[ADDR_W-1:0]),
        .wdata (element),
        .re    (cmd.issue),
        .raddr (src_idx[ADDR_W-1:0]),
        .rdata (value)
    );

    assign out_rows = orows_reg;
    assign out_cols = ocols_reg;
    assign last     = last_reg;

endmodule

>>> rtl/matrix_orientation_undo.sv
// Matrix orientation undo block.
// Input stream: s_tuser carries the mode (load, token, finish); s_tdata carries the
// element and the operation token. Output stream: one transaction per element of the
// re-oriented matrix, with its dimensions; m_tlast marks the final element.
// Config port: cfg_we/cfg_index/cfg_data set matrix_rows (0) and matrix_cols (1);
// write only while the block is idle.
// Load and token transactions produce no output.
// A finish transaction starts the emit pass: the controller enters its emit state, then
// reads the first element into the output register; then one element per cycle while the
// receiver accepts, rows*cols elements total, paced by the single read port of the 64-entry
// element store. s_tready stays low during the pass and rises in the cycle after the last
// element is read; that element may still wait in the output register while new input is taken.
// When the receiver stalls, the output register holds and the store read pauses.
// Reset clears dimensions to 1x1, the load index, flip parity and turn count; the
// element store is not cleared.
// Depends on mou_pkg, mou_ctrl, mou_dp, mou_ram.
module matrix_orientation_undo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mou_pkg::S_TDATA_W-1:0]  s_tdata,   // element[31:0], operation[32], zero pad
    input  logic [mou_pkg::MODE_W-1:0]     s_tuser,   // mode[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mou_pkg::M_TDATA_W-1:0]  m_tdata,   // out_rows[3:0], out_cols[7:4], value[39:8]
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [mou_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mou_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mou_pkg::*;

    cmd_t              cmd;
    status_t           stat;
    logic [DATA_W-1:0] value;
    logic [DIM_W-1:0]  out_rows;
    logic [DIM_W-1:0]  out_cols;

    mou_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    mou_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .element   (s_tdata[DATA_W-1:0]),
        .operation (s_tdata[DATA_W]),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .out_rows  (out_rows),
        .out_cols  (out_cols),
        .last      (m_tlast)
    );

    assign m_tdata = {value, out_cols, out_rows};

endmodule

>>> rtl/mou_checker.sv
// Port-level checker for the matrix orientation undo block, bound to the top level.
// Depends on mou_pkg and matrix_orientation_undo_assert.svh.
`include "matrix_orientation_undo_assert.svh"

module mou_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [mou_pkg::MODE_W-1:0]     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mou_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);
    import mou_pkg::*;

    // stalled output transaction holds
    `MOU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output changed while stalled")

    // a finish transaction closes the input side for the emit pass
    `MOU_ASSERT_NEXT(a_finish_blocks, s_tvalid && s_tready && s_tuser == MODE_FINISH,
        !s_tready, "input accepted right after finish")

    // mid-frame output means the pass is still running
    `MOU_ASSERT_NOW(a_frame_busy, m_tvalid && !m_tlast,
        !s_tready, "input open before the frame was fully read")

    // emitted dimensions are clamped
    `MOU_ASSERT_NOW(a_dims_range, m_tvalid,
        m_tdata[3:0] != 4'd0 && m_tdata[3:0] <= 4'd8 &&
        m_tdata[7:4] != 4'd0 && m_tdata[7:4] <= 4'd8, "output dimensions out of range")

endmodule

bind matrix_orientation_undo mou_checker u_mou_checker (.*);

>>> bench/matrix_orientation_checker.sv
// Checker for matrix_orientation_undo: watches the input, output and config channels,
// predicts the re-oriented matrix for each finish transaction and compares every output.
// Depends on mou_pkg.
module matrix_orientation_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mou_pkg::S_TDATA_W-1:0]   s_tdata,   // element[31:0], operation[32], zero pad
    input  logic [mou_pkg::MODE_W-1:0]      s_tuser,   // mode[1:0]
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mou_pkg::M_TDATA_W-1:0]   m_tdata,   // out_rows[3:0], out_cols[7:4], value[39:8]
    input  logic                            m_tlast,
    input  logic                            cfg_we,
    input  logic [mou_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mou_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mou_pkg::*;

    typedef struct {
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  cols;
        logic [DATA_W-1:0] value;
        logic              last;
    } element_t;

    element_t          expected_elements[$];
    logic [DATA_W-1:0] element_mem [STORE_DEPTH];
    int unsigned       fill_ptr;
    logic              flip_odd;
    logic [1:0]        quarter_turns;
    logic [DIM_W-1:0]  dim_rows;
    logic [DIM_W-1:0]  dim_cols;

    initial errors = 0;
    initial pending = 0;

    task automatic report(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic int unsigned effective_dim(logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return d;
    endfunction

    // queue the re-oriented matrix, then clear the job state
    task automatic emit_matrix();
        int unsigned nrow, ncol, orow, ocol, total, k;
        int unsigned pr, pc, nr, nc, tr, tc, swap;
        logic [ADDR_W-1:0] addr;
        element_t e;
        nrow = effective_dim(dim_rows);
        ncol = effective_dim(dim_cols);
        orow = quarter_turns[0] ? ncol : nrow;
        ocol = quarter_turns[0] ? nrow : ncol;
        total = orow * ocol;
        k = 0;
        for (int unsigned r = 0; r < orow; r++) begin
            for (int unsigned c = 0; c < ocol; c++) begin
                pr = r;
                pc = c;
                nr = orow;
                nc = ocol;
                // walk each counter-clockwise turn back to its source position
                for (int unsigned t = 0; t < quarter_turns; t++) begin
                    tr = pc;
                    tc = nr - 1 - pr;
                    swap = nr;
                    nr = nc;
                    nc = swap;
                    pr = tr;
                    pc = tc;
                end
                if (flip_odd)
                    pr = nrow - 1 - pr;
                addr = ADDR_W'(pr * ncol + pc);
                e.rows = DIM_W'(orow);
                e.cols = DIM_W'(ocol);
                e.value = element_mem[addr];
                e.last = (k + 1 == total);
                expected_elements.push_back(e);
                k++;
            end
        end
        fill_ptr = 0;
        flip_odd = 1'b0;
        quarter_turns = 2'd0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        element_t want;
        if (!rst_n)
        begin
            expected_elements.delete();
            fill_ptr = 0;
            flip_odd = 1'b0;
            quarter_turns = 2'd0;
            dim_rows = DIM_W'(1);
            dim_cols = DIM_W'(1);
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_elements.size() == 0)
                    report($sformatf("output value %0d with nothing expected",
                                     $signed(m_tdata[39:8])));
                else
                begin
                    want = expected_elements.pop_front();
                    if (m_tdata[3:0] != want.rows)
                        report($sformatf("out_rows %0d, expected %0d",
                                         m_tdata[3:0], want.rows));
                    if (m_tdata[7:4] != want.cols)
                        report($sformatf("out_cols %0d, expected %0d",
                                         m_tdata[7:4], want.cols));
                    if (m_tdata[39:8] !== want.value)
                        report($sformatf("value %0d, expected %0d",
                                         $signed(m_tdata[39:8]), $signed(want.value)));
                    if (m_tlast !== want.last)
                        report($sformatf("tlast %0b, expected %0b", m_tlast, want.last));
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROWS: dim_rows = cfg_data;
                    REG_COLS: dim_cols = cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    MODE_LOAD:
                    begin
                        // store full: further loads are dropped
                        if (fill_ptr < STORE_DEPTH)
                        begin
                            element_mem[fill_ptr] = s_tdata[31:0];
                            fill_ptr++;
                        end
                    end
                    MODE_TOKEN:
                    begin
                        if (s_tdata[32] == OP_FLIP)
                            flip_odd = ~flip_odd;
                        else if (!flip_odd)
                            quarter_turns = quarter_turns + 2'd1;
                        else
                            quarter_turns = quarter_turns - 2'd1;
                    end
                    MODE_FINISH: emit_matrix();
                    default: ;
                endcase
            end
            pending <= expected_elements.size();
        end
    end

endmodule

>>> bench/testbench.sv
// Top of the matrix_orientation_undo bench: clock, reset, stimulus and verdict.
// Prediction and comparison live in matrix_orientation_checker.
// Depends on mou_pkg, matrix_orientation_undo and matrix_orientation_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mou_pkg::*;

    localparam int ITEM_TARGET = 200;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [MODE_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int  errors;
    int  pending;
    int  cycles = 0;
    int  items_sent = 0;
    bit  steady = 1'b0;

    matrix_orientation_undo uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    matrix_orientation_checker check (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= 36);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(logic [MODE_W-1:0] mode, logic [31:0] elem, logic op);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {7'b0, op, elem};
        do
            @(posedge clk);
        while (!s_tready);
        if (mode != MODE_UNUSED)
            items_sent++;
    endtask

    // hold the input until every queued output has drained
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_element();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_dim();
        case ($urandom_range(9))
            0: return 4'd0;
            1: return CFG_DATA_W'($urandom_range(15, 9));
            2: return 4'd8;
            default: return CFG_DATA_W'($urandom_range(4, 1));
        endcase
    endfunction

    // loads, tokens and ignored transactions in random order, then finish
    task automatic run_job(int loads, int tokens, int noise);
        int pick;
        while (loads + tokens + noise > 0)
        begin
            pick = $urandom_range(loads + tokens + noise - 1);
            if (pick < loads)
            begin
                send_item(MODE_LOAD, random_element(), 1'($urandom));
                loads--;
            end
            else if (pick < loads + tokens)
            begin
                send_item(MODE_TOKEN, $urandom, $urandom_range(1) ? OP_FLIP : OP_TURN);
                tokens--;
            end
            else
            begin
                send_item(MODE_UNUSED, $urandom, 1'($urandom));
                noise--;
            end
        end
        send_item(MODE_FINISH, $urandom, 1'($urandom));
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] rows_set;
        logic [CFG_DATA_W-1:0] cols_set;
        int job;
        int loads;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // 1x1 from reset, then an ignored mode
        send_item(MODE_LOAD, 32'h8000_0000, 1'b1);
        send_item(MODE_FINISH, 32'h0, 1'b0);
        send_item(MODE_UNUSED, 32'hffff_ffff, 1'b1);

        settle();
        write_reg(REG_ROWS, 4'd2);
        write_reg(REG_COLS, 4'd3);
        send_item(MODE_LOAD, 32'h7fff_ffff, 1'b0);
        send_item(MODE_LOAD, 32'hffff_ffff, 1'b1);
        send_item(MODE_LOAD, 32'h0000_0000, 1'b0);
        send_item(MODE_LOAD, 32'h0000_0001, 1'b1);
        send_item(MODE_LOAD, 32'h8000_0000, 1'b0);
        send_item(MODE_LOAD, 32'h1234_5678, 1'b0);
        // flip then turn: odd parity walks the count backward
        send_item(MODE_TOKEN, 32'hffff_ffff, OP_FLIP);
        send_item(MODE_TOKEN, 32'h0, OP_TURN);
        send_item(MODE_FINISH, 32'h0, 1'b0);
        // the store keeps its contents, so no reload is needed
        send_item(MODE_TOKEN, 32'h0, OP_TURN);
        send_item(MODE_FINISH, 32'h0, 1'b0);
        send_item(MODE_TOKEN, 32'h0, OP_FLIP);
        send_item(MODE_TOKEN, 32'h0, OP_TURN);
        send_item(MODE_TOKEN, 32'h0, OP_TURN);
        send_item(MODE_FINISH, 32'h0, 1'b0);

        rows_set = 4'd2;
        cols_set = 4'd3;
        job = 0;
        while (items_sent < ITEM_TARGET)
        begin
            steady = (job >= 4 && job < 9);
            if (job == 0)
            begin
                // fill the whole store and overrun it; every entry is written from here on
                settle();
                rows_set = 4'd8;
                cols_set = 4'd8;
                write_reg(REG_ROWS, rows_set);
                write_reg(REG_COLS, cols_set);
                run_job(STORE_DEPTH + 2, $urandom_range(7), 0);
            end
            else
            begin
                if ($urandom_range(2) == 0)
                begin
                    settle();
                    if ($urandom_range(3) != 0)
                    begin
                        rows_set = random_dim();
                        write_reg(REG_ROWS, rows_set);
                    end
                    if ($urandom_range(3) != 0)
                    begin
                        cols_set = random_dim();
                        write_reg(REG_COLS, cols_set);
                    end
                end
                if (rows_set >= 1 && rows_set <= 4 && cols_set >= 1 && cols_set <= 4
                    && $urandom_range(4) != 0)
                    loads = rows_set * cols_set + (($urandom_range(3) == 0) ?
                                                   $urandom_range(2, 1) : 0);
                else
                    loads = $urandom_range(6);
                run_job(loads, $urandom_range(7), ($urandom_range(4) == 0) ? 1 : 0);
            end
            job++;
        end
        steady = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/mou_pkg.sv
rtl/mou_ram.sv
rtl/mou_ctrl.sv
rtl/mou_dp.sv
rtl/matrix_orientation_undo.sv
rtl/mou_checker.sv
bench/matrix_orientation_checker.sv
bench/testbench.sv
